FILE: design/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, widths and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int unsigned REG_W          = 13;
   localparam int unsigned ADDR_W         = 24;
   localparam int unsigned STATUS_W       = 2;
   localparam int unsigned CSR_IDX_W      = 1;

   // page size is fixed, a power of two
   localparam int unsigned PAGE_BYTES     = 4096;
   localparam int unsigned PAGE_SHIFT     = $clog2(PAGE_BYTES);
   localparam int unsigned FPAGE_W        = ADDR_W - PAGE_SHIFT;
   localparam int unsigned CMP_W          = (FPAGE_W > REG_W) ? FPAGE_W : REG_W;

   // map word width must be a power of two
   localparam int unsigned DEF_MAX_PAGES  = 4096;
   localparam int unsigned DEF_WORD_BITS  = 32;

   localparam logic [REG_W-1:0] TOTAL_RESET    = REG_W'(4096);
   localparam logic [REG_W-1:0] RESERVED_RESET = REG_W'(1);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_PAGE  = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NOT_HELD = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL_PAGES    = 1'b0,
      CSR_RESERVED_PAGES = 1'b1
   } csr_index_type;

endpackage

FILE: design/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bpa_word_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_word_find
// Finds the lowest clear bit of one map word inside the allowed page window.
// ----------------------------------------------------------------------------
module bpa_word_find #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]         word,
   input  logic                         first,
   input  logic [$clog2(WORD_BITS)-1:0] first_bit,
   input  logic                         last,
   input  logic [$clog2(WORD_BITS)-1:0] last_bit,
   output logic                         found,
   output logic [$clog2(WORD_BITS)-1:0] bit_idx
);

   localparam int unsigned LW = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] cand;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         cand[b] = !word[b]
                   && (!first || (LW'(b) >= first_bit))
                   && (!last  || (LW'(b) <= last_bit));
      end
   end

   // lowest candidate wins
   always_comb begin
      found   = 1'b0;
      bit_idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            found   = 1'b1;
            bit_idx = LW'(b);
         end
      end
   end

endmodule

FILE: design/bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit physical page allocator over a used-page bitmap held in RAM.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_opcode, req_free_address
//   rsp      out        rsp_valid/rsp_stall  rsp_page_address, rsp_status,
//                                            rsp_free_pages
//   csr      in         csr_write            csr_index, csr_data
//
// an allocate scans one map word per cycle through the word finder,
// from the first word of the range up to a hit or the last word;
// a free reads, checks and writes back its map word; a request refused on
// its range skips the map. One request at a time: req_stall is high from
// acceptance until the result is in the output register; rsp_stall holds that register
// reset is synchronous; per-word valid flags make the map read as all clear
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core
   import bpa_pkg::*;
#(
   parameter int unsigned MAX_PAGES     = DEF_MAX_PAGES,
   parameter int unsigned MAP_WORD_BITS = DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [ADDR_W-1:0]    req_free_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_page_address,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [REG_W-1:0]     rsp_free_pages,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   localparam int unsigned MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int unsigned WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned LW        = $clog2(MAP_WORD_BITS);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_SCAN     = 5'b00010,
      S_FREE_RD  = 5'b00100,
      S_FREE_CHK = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [REG_W-1:0]        total_ff, total_in;
   logic [REG_W-1:0]        reserved_ff, reserved_in;
   logic [REG_W-1:0]        count_ff, count_in;
   logic [CMP_W-1:0]        page_ff, page_in;
   logic [WI_W-1:0]         rd_w_ff, rd_w_in;
   logic                    rd_live_ff, rd_live_in;
   logic [WI_W-1:0]         chk_w_ff, chk_w_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [MAP_WORDS-1:0]    word_vld_ff, word_vld_in;
   logic [ADDR_W-1:0]       res_addr_ff, res_addr_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [REG_W-1:0]        rsp_free_ff, rsp_free_in;

   logic [REG_W-1:0]         lim;
   logic [REG_W-1:0]         lim_m1;
   logic                     span_ok;
   logic [REG_W-1:0]         span;
   logic [REG_W-1:0]         free_now;
   logic [WI_W-1:0]          first_w;
   logic [WI_W-1:0]          last_w;
   logic [CMP_W-1:0]         req_page;
   logic [WI_W-1:0]          free_w;
   logic                     ram_we;
   logic [WI_W-1:0]          ram_waddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata;
   logic                     ram_re;
   logic [WI_W-1:0]          ram_raddr;
   logic [MAP_WORD_BITS-1:0] ram_q;
   logic [MAP_WORD_BITS-1:0] word;
   logic                     find_hit;
   logic [LW-1:0]            find_bit;
   logic [LW-1:0]            free_bit;
   logic                     out_free;

   // dynamic range
   always_comb begin
      if (32'(total_ff) < MAX_PAGES) begin
         lim = total_ff;
      end else begin
         lim = REG_W'(MAX_PAGES);
      end
   end

   assign lim_m1   = lim - REG_W'(1);
   assign span_ok  = reserved_ff < lim;
   assign span     = span_ok ? (lim - reserved_ff) : '0;
   assign free_now = (count_ff < span) ? (span - count_ff) : '0;
   assign first_w  = WI_W'(reserved_ff >> LW);
   assign last_w   = WI_W'(lim_m1 >> LW);
   assign req_page = CMP_W'(req_free_address >> PAGE_SHIFT);
   assign free_w   = WI_W'(page_ff >> LW);
   assign free_bit = page_ff[LW-1:0];
   assign word     = rd_vld_ff ? ram_q : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign ram_re    = (state_ff == S_FREE_RD) || ((state_ff == S_SCAN) && rd_live_ff);
   assign ram_raddr = (state_ff == S_FREE_RD) ? free_w : rd_w_ff;

   bpa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   bpa_word_find #(
      .WORD_BITS (MAP_WORD_BITS)
   ) u_find (
      .word      (word),
      .first     (chk_w_ff == first_w),
      .first_bit (reserved_ff[LW-1:0]),
      .last      (chk_w_ff == last_w),
      .last_bit  (lim_m1[LW-1:0]),
      .found     (find_hit),
      .bit_idx   (find_bit)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      page_in       = page_ff;
      rd_w_in       = rd_w_ff;
      rd_live_in    = rd_live_ff;
      chk_w_in      = chk_w_ff;
      chk_vld_in    = chk_vld_ff;
      rd_vld_in     = rd_vld_ff;
      word_vld_in   = word_vld_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_w_ff;
      ram_wdata     = word;

      if (ram_re) begin
         rd_vld_in = word_vld_ff[ram_raddr];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in     = req_page;
               res_addr_in = '0;
               if (opcode_type'(req_opcode) == OP_ALLOC) begin
                  if (span_ok) begin
                     rd_w_in    = first_w;
                     rd_live_in = 1'b1;
                     chk_vld_in = 1'b0;
                     state_in   = S_SCAN;
                  end else begin
                     res_status_in = ST_NO_PAGE;
                     state_in      = S_DONE;
                  end
               end else begin
                  if ((req_page < CMP_W'(reserved_ff)) || (req_page >= CMP_W'(lim))) begin
                     res_status_in = ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_FREE_RD;
                  end
               end
            end
         end
         S_SCAN: begin
            // issue side
            if (rd_live_ff) begin
               chk_w_in   = rd_w_ff;
               chk_vld_in = 1'b1;
               if (rd_w_ff == last_w) begin
                  rd_live_in = 1'b0;
               end else begin
                  rd_w_in = rd_w_ff + WI_W'(1);
               end
            end else begin
               chk_vld_in = 1'b0;
            end
            // check side
            if (chk_vld_ff) begin
               if (find_hit) begin
                  ram_we      = 1'b1;
                  ram_wdata   = word | (MAP_WORD_BITS'(1) << find_bit);
                  word_vld_in[chk_w_ff] = 1'b1;
                  count_in    = count_ff + REG_W'(1);
                  res_addr_in = ADDR_W'({chk_w_ff, find_bit, {PAGE_SHIFT{1'b0}}});
                  res_status_in = ST_OK;
                  rd_live_in  = 1'b0;
                  chk_vld_in  = 1'b0;
                  state_in    = S_DONE;
               end else if (chk_w_ff == last_w) begin
                  res_status_in = ST_NO_PAGE;
                  rd_live_in    = 1'b0;
                  chk_vld_in    = 1'b0;
                  state_in      = S_DONE;
               end
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (!word[free_bit]) begin
               res_status_in = ST_NOT_HELD;
            end else begin
               ram_we        = 1'b1;
               ram_waddr     = free_w;
               ram_wdata     = word & ~(MAP_WORD_BITS'(1) << free_bit);
               word_vld_in[free_w] = 1'b1;
               res_status_in = ST_OK;
               if (count_ff != '0) begin
                  count_in = count_ff - REG_W'(1);
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_free_in   = free_now;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOTAL_PAGES:    total_in    = csr_data;
            CSR_RESERVED_PAGES: reserved_in = csr_data;
            default: begin
               total_in    = total_ff;
               reserved_in = reserved_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= TOTAL_RESET;
         reserved_ff  <= RESERVED_RESET;
         count_ff     <= '0;
         rd_live_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         word_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
         count_ff     <= count_in;
         rd_live_ff   <= rd_live_in;
         chk_vld_ff   <= chk_vld_in;
         rd_vld_ff    <= rd_vld_in;
         word_vld_ff  <= word_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      rd_w_ff       <= rd_w_in;
      chk_w_ff      <= chk_w_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_pages   = rsp_free_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_page_allocator_core. A short table of
// directed requests and register writes covers the range edges, the error
// statuses and the register corner cases. Random phases follow, each with
// its own page range and one of four mixes of sender gaps and receiver
// stalls. Every response word is checked field by field against the table's
// word or a bench-side model of the used-page map and the allocation count.
// ----------------------------------------------------------------------------
module tb_top;
   import bpa_pkg::*;

   localparam int unsigned N_PHASES     = 9;
   localparam int unsigned PHASE_WORDS  = 214;
   localparam int unsigned DRAIN_CYCLES = DEF_MAX_PAGES / DEF_WORD_BITS + 12;

   typedef struct packed {
      logic [ADDR_W-1:0] page_address;
      status_type        status;
      logic [REG_W-1:0]  free_pages;
   } page_outcome_type;

   typedef enum {ROW_REQUEST, ROW_WRITE} plan_kind_type;

   typedef struct {
      plan_kind_type     kind;
      opcode_type        op;
      logic [ADDR_W-1:0] addr;
      csr_index_type     idx;
      bit                typed;
      page_outcome_type  outcome;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_ALLOC;
   logic [ADDR_W-1:0]    req_free_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ADDR_W-1:0]    rsp_page_address;
   logic [STATUS_W-1:0]  rsp_status;
   logic [REG_W-1:0]     rsp_free_pages;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TOTAL_PAGES;
   logic [REG_W-1:0]     csr_data = '0;

   // bench copy of the allocator state
   bit [DEF_MAX_PAGES-1:0] page_held;
   int unsigned            held_count;
   logic [REG_W-1:0]       cfg_total;
   logic [REG_W-1:0]       cfg_reserved;

   page_outcome_type outcome_queue[$];
   page_outcome_type oldest;
   plan_row_type     plan[$];

   int          send_idle_pct;
   int          stall_pct;
   int          error_count;
   int unsigned words_sent;
   int unsigned grants;
   int unsigned no_page_count;
   int unsigned frees_done;
   int unsigned frees_rejected;

   int unsigned phase_total[N_PHASES]    = '{4096, 64, 40, 8191, 1, 0, 0, 4096, 200};
   int unsigned phase_reserved[N_PHASES] = '{1, 1, 8, 3990, 0, 0, 0, 4095, 0};
   int          phase_send_pct[4]        = '{0, 86, 0, 10};
   int          phase_stall_pct[4]       = '{0, 0, 86, 10};

   bitmap_page_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_page_address (rsp_page_address),
      .rsp_status       (rsp_status),
      .rsp_free_pages   (rsp_free_pages),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int page_limit();
      return (cfg_total < DEF_MAX_PAGES) ? int'(cfg_total) : int'(DEF_MAX_PAGES);
   endfunction

   // first-fit allocate or release, returns the response word
   function automatic page_outcome_type apply_page_request(opcode_type op,
                                                           logic [ADDR_W-1:0] addr);
      page_outcome_type res;
      int lim;
      int p;
      int span;
      lim = page_limit();
      res.page_address = '0;
      res.status = ST_OK;
      if (op == OP_ALLOC) begin
         p = int'(cfg_reserved);
         while (p < lim && page_held[p]) p++;
         if (p < lim) begin
            page_held[p] = 1'b1;
            held_count++;
            res.page_address = ADDR_W'(p) << PAGE_SHIFT;
         end else begin
            res.status = ST_NO_PAGE;
         end
      end else begin
         p = int'(addr >> PAGE_SHIFT);
         if (p < int'(cfg_reserved) || p >= lim) begin
            res.status = ST_RANGE;
         end else if (!page_held[p]) begin
            res.status = ST_NOT_HELD;
         end else begin
            page_held[p] = 1'b0;
            if (held_count > 0) held_count--;
         end
      end
      span = (int'(cfg_reserved) < lim) ? lim - int'(cfg_reserved) : 0;
      res.free_pages = REG_W'((int'(held_count) < span) ? span - int'(held_count) : 0);
      return res;
   endfunction

   function automatic void plan_request(opcode_type op, logic [ADDR_W-1:0] addr);
      plan_row_type r;
      r.kind = ROW_REQUEST;
      r.op = op;
      r.addr = addr;
      r.idx = CSR_TOTAL_PAGES;
      r.typed = 1'b0;
      r.outcome = '0;
      plan.push_back(r);
   endfunction

   function automatic void plan_checked(opcode_type op, logic [ADDR_W-1:0] addr,
                                        logic [ADDR_W-1:0] pa, status_type st,
                                        logic [REG_W-1:0] fp);
      plan_row_type r;
      r.kind = ROW_REQUEST;
      r.op = op;
      r.addr = addr;
      r.idx = CSR_TOTAL_PAGES;
      r.typed = 1'b1;
      r.outcome.page_address = pa;
      r.outcome.status = st;
      r.outcome.free_pages = fp;
      plan.push_back(r);
   endfunction

   function automatic void plan_write(csr_index_type idx, logic [REG_W-1:0] val);
      plan_row_type r;
      r.kind = ROW_WRITE;
      r.op = OP_ALLOC;
      r.addr = ADDR_W'(val);
      r.idx = idx;
      r.typed = 1'b0;
      r.outcome = '0;
      plan.push_back(r);
   endfunction

   task automatic issue_request(opcode_type op, logic [ADDR_W-1:0] addr, bit typed,
                                page_outcome_type typed_out);
      page_outcome_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_free_address <= addr;
      do @(posedge clock); while (req_stall);
      got = apply_page_request(op, addr);
      outcome_queue.push_back(typed ? typed_out : got);
      words_sent++;
      case (got.status)
         ST_OK: begin
            if (op == OP_ALLOC) grants++;
            else frees_done++;
         end
         ST_NO_PAGE: no_page_count++;
         default: frees_rejected++;
      endcase
   endtask

   // registers change only once the block has gone quiet
   task automatic write_register(csr_index_type idx, logic [REG_W-1:0] val);
      req_valid <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TOTAL_PAGES) cfg_total = val;
      else cfg_reserved = val;
   endtask

   // response side: random stalls and word checks
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_queue.size() == 0) begin
               $display("%0t: unexpected word addr %h status %0d free %0d", $time,
                        rsp_page_address, rsp_status, rsp_free_pages);
               error_count++;
            end else begin
               oldest = outcome_queue.pop_front();
               if (rsp_page_address !== oldest.page_address) begin
                  $display("%0t: page_address expected %h actual %h", $time,
                           oldest.page_address, rsp_page_address);
                  error_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           oldest.status, rsp_status);
                  error_count++;
               end
               if (rsp_free_pages !== oldest.free_pages) begin
                  $display("%0t: free_pages expected %0d actual %0d", $time,
                           oldest.free_pages, rsp_free_pages);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      int pick;
      int lim;
      int lo;
      int page;
      opcode_type op;
      logic [ADDR_W-1:0] addr;
      int unsigned tot;
      int unsigned res;

      page_held = '0;
      held_count = 0;
      cfg_total = TOTAL_RESET;
      cfg_reserved = RESERVED_RESET;
      error_count = 0;
      send_idle_pct = 10;
      stall_pct = 10;

      // directed rows, from the reset range of 4096 pages with page 0 reserved
      plan_checked(OP_ALLOC, 24'h000000, 24'h001000, ST_OK, 13'd4094);
      plan_request(OP_ALLOC, 24'h000000);
      plan_request(OP_FREE, 24'h001000);
      plan_checked(OP_FREE, 24'h001FFF, 24'h000000, ST_NOT_HELD, 13'd4094);
      plan_checked(OP_FREE, 24'h000000, 24'h000000, ST_RANGE, 13'd4094);
      plan_checked(OP_FREE, 24'hFFFFFF, 24'h000000, ST_NOT_HELD, 13'd4094);
      plan_request(OP_ALLOC, 24'hFFFFFF);
      plan_request(OP_FREE, 24'h002ABC);
      plan_write(CSR_TOTAL_PAGES, 13'd3);
      plan_request(OP_ALLOC, 24'h000000);
      plan_checked(OP_ALLOC, 24'h000000, 24'h000000, ST_NO_PAGE, 13'd0);
      plan_checked(OP_FREE, 24'h003000, 24'h000000, ST_RANGE, 13'd0);
      // empty range
      plan_write(CSR_RESERVED_PAGES, 13'd3);
      plan_checked(OP_ALLOC, 24'h000000, 24'h000000, ST_NO_PAGE, 13'd0);
      plan_checked(OP_FREE, 24'h001000, 24'h000000, ST_RANGE, 13'd0);
      plan_write(CSR_RESERVED_PAGES, 13'd0);
      plan_write(CSR_TOTAL_PAGES, 13'd0);
      plan_checked(OP_ALLOC, 24'h000000, 24'h000000, ST_NO_PAGE, 13'd0);
      plan_checked(OP_FREE, 24'h000000, 24'h000000, ST_RANGE, 13'd0);
      // oversized total clamps to the map size
      plan_write(CSR_TOTAL_PAGES, 13'h1FFF);
      plan_request(OP_ALLOC, 24'h000000);
      plan_request(OP_FREE, 24'hFFF000);
      plan_write(CSR_RESERVED_PAGES, 13'h1FFF);
      plan_checked(OP_ALLOC, 24'h000000, 24'h000000, ST_NO_PAGE, 13'd0);
      plan_checked(OP_FREE, 24'hFFFFFF, 24'h000000, ST_RANGE, 13'd0);
      // more pages held than the range holds, free count saturates
      plan_write(CSR_RESERVED_PAGES, 13'd1);
      plan_write(CSR_TOTAL_PAGES, 13'd3);
      plan_checked(OP_ALLOC, 24'h000000, 24'h000000, ST_NO_PAGE, 13'd0);
      plan_checked(OP_FREE, 24'h000FFF, 24'h000000, ST_RANGE, 13'd0);
      plan_request(OP_FREE, 24'h002000);
      plan_write(CSR_TOTAL_PAGES, 13'd4096);
      plan_request(OP_FREE, 24'h001000);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE)
            write_register(plan[i].idx, REG_W'(plan[i].addr));
         else
            issue_request(plan[i].op, plan[i].addr, plan[i].typed, plan[i].outcome);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         tot = phase_total[ph];
         res = phase_reserved[ph];
         // zero total here means a random small range
         if (tot == 0) begin
            tot = $urandom_range(256, 1);
            res = $urandom_range(16, 0);
         end
         write_register(CSR_TOTAL_PAGES, REG_W'(tot));
         write_register(CSR_RESERVED_PAGES, REG_W'(res));
         send_idle_pct = phase_send_pct[ph % 4];
         stall_pct = phase_stall_pct[ph % 4];
         repeat (PHASE_WORDS) begin
            pick = $urandom_range(99);
            lim = page_limit();
            lo = int'(cfg_reserved);
            op = OP_FREE;
            addr = ADDR_W'($urandom);
            if (pick < 52) begin
               op = OP_ALLOC;
            end else if (pick < 92 && lo < lim) begin
               page = $urandom_range(lim - 1, lo);
               // mostly release a page that is really held
               if (pick < 84)
                  for (int k = 0; k < lim - lo && !page_held[page]; k++)
                     page = (page + 1 < lim) ? page + 1 : lo;
               addr = (ADDR_W'(page) << PAGE_SHIFT) |
                      ADDR_W'($urandom_range(PAGE_BYTES - 1));
            end
            issue_request(op, addr, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words over %0d range settings and four idling mixes",
               words_sent, N_PHASES + 1);
      $display("%0d pages granted, %0d out of pages, %0d released, %0d releases refused",
               grants, no_page_count, frees_done, frees_rejected);
      if (error_count == 0)
         $display("PASS bitmap_page_allocator_core");
      else
         $display("FAIL bitmap_page_allocator_core");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d words outstanding", outcome_queue.size());
      $display("FAIL bitmap_page_allocator_core");
      $finish;
   end

endmodule

FILE: filelist.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_word_find.sv
design/bitmap_page_allocator_core.sv
verif/tb_top.sv
